/* hdl/min_heap_timer_queue_defines.svh */
// assertion macros for the timer queue checker
// needs clk and rst in the scope where a macro is used
`ifndef MIN_HEAP_TIMER_QUEUE_DEFINES_SVH
`define MIN_HEAP_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication, held off during reset
`define HMTQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define HMTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/hmtq_pkg.sv */
// shared types and constants for the min-heap timer queue
// no dependencies
package hmtq_pkg;

  localparam int TIME_BITS   = 32;
  localparam int HANDLE_BITS = 8;
  localparam int DELAY_BITS  = 20;
  localparam int ACTION_BITS = 2;
  localparam int KIND_BITS   = 3;
  localparam int PEND_BITS   = 6;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_ADD    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_TICK   = 2'd2
  } action_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ADD_OK    = 3'd0,
    KIND_ADD_FULL  = 3'd1,
    KIND_CANCEL_OK = 3'd2,
    KIND_FIRED     = 3'd3,
    KIND_DONE      = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_TK_RD,
    ST_TK_CHK,
    ST_DN_RD,
    ST_DN_SEL,
    ST_DN_CMP,
    ST_TK_FIRE
  } state_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   expiry;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [HANDLE_BITS-1:0] handle;
    logic [DELAY_BITS-1:0]  delay;
    logic [TIME_BITS-1:0]   now;
  } in_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [HANDLE_BITS-1:0] fired_handle;
    logic [PEND_BITS-1:0]   pending;
    logic                   last;
  } out_t;

endpackage

/* hdl/hmtq_heap_ram.sv */
// heap entry memory: one write port, two registered read ports
// depends on hmtq_pkg
module hmtq_heap_ram #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  hmtq_pkg::entry_t         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output hmtq_pkg::entry_t         rd_data_a,
  output hmtq_pkg::entry_t         rd_data_b
);
  import hmtq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

/* hdl/hmtq_cancel.sv */
// per-handle cancel marks, with valid bits so reset clears them at once
// depends on hmtq_pkg
module hmtq_cancel (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [hmtq_pkg::HANDLE_BITS-1:0] wr_addr,
  input  logic                             wr_data,
  input  logic [hmtq_pkg::HANDLE_BITS-1:0] rd_addr,
  output logic                             rd_data
);
  import hmtq_pkg::*;

  localparam int NUM = 1 << HANDLE_BITS;

  logic           mem [NUM];
  logic [NUM-1:0] vld;
  logic           mark_q;
  logic           vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    mark_q <= mem[rd_addr];
    vld_q  <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // an entry never written reads as not cancelled
  assign rd_data = mark_q & vld_q;

endmodule

/* hdl/min_heap_timer_queue.sv */
// timer queue: a cancel or a rejected add answers in the cycle after accept; an add does
// one parent read and one compare per heap level. a tick reads the root and checks it against
// now; each due entry is popped and the last entry sifted down from the root, with a read of
// both children, a select and a compare per level, all on the single compare unit and memory.
// one item at a time: busy is low again by the cycle of the item's last result.
// synchronous reset empties the heap and clears every cancel mark at once.
module min_heap_timer_queue #(
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  hmtq_pkg::in_t  cmd,
  output logic           busy,
  output logic           strobe,
  output hmtq_pkg::out_t result
);
  import hmtq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CH_W  = IDX_W + 2;

  state_t                 state, state_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [IDX_W-1:0]       pos, pos_next;
  entry_t                 hold_ent, hold_ent_next;
  entry_t                 child_ent, child_ent_next;
  logic [IDX_W-1:0]       child_idx, child_idx_next;
  logic [HANDLE_BITS-1:0] pop_handle, pop_handle_next;
  logic [TIME_BITS-1:0]   now_q, now_q_next;
  logic                   strobe_next;
  out_t                   result_next;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_wa, ram_ra, ram_rb;
  entry_t                 ram_wd, ram_qa, ram_qb;
  logic                   cm_we, cm_wd, cm_q;
  logic [HANDLE_BITS-1:0] cm_wa, cm_ra;

  logic [TIME_BITS:0]     sum;
  logic [TIME_BITS-1:0]   add_exp;
  logic                   full;
  logic [CNT_W-1:0]       cnt_m1;
  logic [IDX_W-1:0]       par;
  logic [CH_W-1:0]        lchild, rchild, cnt_ext;
  logic [TIME_BITS-1:0]   cmp_a, cmp_b;
  logic                   lt;
  logic                   due;

  hmtq_heap_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk       (clk),
    .we        (ram_we),
    .wr_addr   (ram_wa),
    .wr_data   (ram_wd),
    .rd_addr_a (ram_ra),
    .rd_addr_b (ram_rb),
    .rd_data_a (ram_qa),
    .rd_data_b (ram_qb)
  );

  hmtq_cancel u_cancel (
    .clk     (clk),
    .rst     (rst),
    .we      (cm_we),
    .wr_addr (cm_wa),
    .wr_data (cm_wd),
    .rd_addr (cm_ra),
    .rd_data (cm_q)
  );

  assign busy    = (state != ST_IDLE);
  assign sum     = {1'b0, cmd.now} + (TIME_BITS + 1)'(cmd.delay);
  assign add_exp = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign full    = (count >= CNT_W'(CAPACITY));
  assign cnt_m1  = count - CNT_W'(1);
  assign par     = (pos - IDX_W'(1)) >> 1;
  assign lchild  = CH_W'({pos, 1'b1});
  assign rchild  = lchild + CH_W'(1);
  assign cnt_ext = CH_W'(count);

  // shared compare unit
  always_comb begin
    case (state)
      ST_TK_CHK: begin
        cmp_a = now_q;
        cmp_b = ram_qa.expiry;
      end
      ST_UP_CMP: begin
        cmp_a = hold_ent.expiry;
        cmp_b = ram_qa.expiry;
      end
      ST_DN_SEL: begin
        cmp_a = ram_qb.expiry;
        cmp_b = ram_qa.expiry;
      end
      default: begin
        cmp_a = child_ent.expiry;
        cmp_b = hold_ent.expiry;
      end
    endcase
  end

  assign lt  = (cmp_a < cmp_b);
  // root expires at or before now
  assign due = (count != '0) && !lt;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd.action)
            ACT_ADD:    state_next = full ? ST_IDLE : ST_UP_RD;
            ACT_TICK:   state_next = ST_TK_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_UP_RD:   state_next = (pos == '0) ? ST_IDLE : ST_UP_CMP;
      ST_UP_CMP:  state_next = lt ? ST_UP_RD : ST_IDLE;
      ST_TK_RD:   state_next = ST_TK_CHK;
      ST_TK_CHK: begin
        if (!due) begin
          state_next = ST_IDLE;
        end else if (count == CNT_W'(1)) begin
          state_next = ST_TK_FIRE;
        end else begin
          state_next = ST_DN_RD;
        end
      end
      ST_DN_RD:   state_next = (lchild >= cnt_ext) ? ST_TK_FIRE : ST_DN_SEL;
      ST_DN_SEL:  state_next = ST_DN_CMP;
      ST_DN_CMP:  state_next = lt ? ST_DN_RD : ST_TK_FIRE;
      ST_TK_FIRE: state_next = ST_TK_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory controls and result
  always_comb begin
    ram_we      = 1'b0;
    ram_wa      = pos;
    ram_wd      = hold_ent;
    ram_ra      = '0;
    ram_rb      = cnt_m1[IDX_W-1:0];
    cm_we       = 1'b0;
    cm_wa       = cmd.handle;
    cm_wd       = 1'b0;
    cm_ra       = pop_handle;
    strobe_next = 1'b0;
    result_next = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd.action)
            ACT_ADD: begin
              if (full) begin
                strobe_next              = 1'b1;
                result_next.kind         = KIND_ADD_FULL;
                result_next.fired_handle = cmd.handle;
                result_next.pending      = PEND_BITS'(count);
                result_next.last         = 1'b1;
              end else begin
                cm_we = 1'b1;
              end
            end
            ACT_CANCEL: begin
              cm_we                    = 1'b1;
              cm_wd                    = 1'b1;
              strobe_next              = 1'b1;
              result_next.kind         = KIND_CANCEL_OK;
              result_next.fired_handle = cmd.handle;
              result_next.pending      = PEND_BITS'(count);
              result_next.last         = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_UP_RD: begin
        if (pos == '0) begin
          ram_we                   = 1'b1;
          strobe_next              = 1'b1;
          result_next.kind         = KIND_ADD_OK;
          result_next.fired_handle = hold_ent.handle;
          result_next.pending      = PEND_BITS'(count);
          result_next.last         = 1'b1;
        end else begin
          ram_ra = par;
        end
      end
      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (lt) begin
          // parent moves down into the hole
          ram_wd = ram_qa;
        end else begin
          strobe_next              = 1'b1;
          result_next.kind         = KIND_ADD_OK;
          result_next.fired_handle = hold_ent.handle;
          result_next.pending      = PEND_BITS'(count);
          result_next.last         = 1'b1;
        end
      end
      ST_TK_CHK: begin
        cm_ra = ram_qa.handle;
        if (!due) begin
          strobe_next         = 1'b1;
          result_next.kind    = KIND_DONE;
          result_next.pending = PEND_BITS'(count);
          result_next.last    = 1'b1;
        end
      end
      ST_DN_RD: begin
        if (lchild >= cnt_ext) begin
          ram_we = 1'b1;
        end else begin
          ram_ra = lchild[IDX_W-1:0];
          ram_rb = rchild[IDX_W-1:0];
        end
      end
      ST_DN_CMP: begin
        ram_we = 1'b1;
        if (lt) begin
          ram_wd = child_ent;
        end
      end
      ST_TK_FIRE: begin
        if (!cm_q) begin
          strobe_next              = 1'b1;
          result_next.kind         = KIND_FIRED;
          result_next.fired_handle = pop_handle;
          result_next.pending      = PEND_BITS'(count);
        end
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    count_next      = count;
    pos_next        = pos;
    hold_ent_next   = hold_ent;
    child_ent_next  = child_ent;
    child_idx_next  = child_idx;
    pop_handle_next = pop_handle;
    now_q_next      = now_q;
    case (state)
      ST_IDLE: begin
        if (start && cmd.action == ACT_ADD && !full) begin
          hold_ent_next.expiry = add_exp;
          hold_ent_next.handle = cmd.handle;
          pos_next             = count[IDX_W-1:0];
          count_next           = count + CNT_W'(1);
        end
        if (start && cmd.action == ACT_TICK) begin
          now_q_next = cmd.now;
        end
      end
      ST_UP_CMP: begin
        if (lt) begin
          pos_next = par;
        end
      end
      ST_TK_CHK: begin
        if (due) begin
          // last entry becomes the one to sift down from the root
          pop_handle_next = ram_qa.handle;
          count_next      = cnt_m1;
          hold_ent_next   = ram_qb;
          pos_next        = '0;
        end
      end
      ST_DN_SEL: begin
        if (rchild < cnt_ext && lt) begin
          child_ent_next = ram_qb;
          child_idx_next = rchild[IDX_W-1:0];
        end else begin
          child_ent_next = ram_qa;
          child_idx_next = lchild[IDX_W-1:0];
        end
      end
      ST_DN_CMP: begin
        if (lt) begin
          pos_next = child_idx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    hold_ent   <= hold_ent_next;
    child_ent  <= child_ent_next;
    child_idx  <= child_idx_next;
    pop_handle <= pop_handle_next;
    now_q      <= now_q_next;
    result     <= result_next;
  end

endmodule

/* hdl/hmtq_checker.sv */
// port-level checks for the timer queue, bound onto the top level
// depends on hmtq_pkg and min_heap_timer_queue_defines.svh
`include "min_heap_timer_queue_defines.svh"

module hmtq_checker #(
  parameter int CAPACITY = 32
) (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input hmtq_pkg::in_t  cmd,
  input logic           busy,
  input logic           strobe,
  input hmtq_pkg::out_t result
);
  import hmtq_pkg::*;

  `HMTQ_ASSERT_NEXT(a_cancel_ack, start && !busy && cmd.action == ACT_CANCEL, strobe && result.kind == KIND_CANCEL_OK && result.last && result.fired_handle == $past(cmd.handle), "cancel item not acknowledged next cycle")
  `HMTQ_ASSERT_NEXT(a_tick_busy, start && !busy && cmd.action == ACT_TICK, busy && !strobe, "tick item did not hold busy")
  `HMTQ_ASSERT_IMP(a_done_last, strobe && result.kind == KIND_DONE, result.last && result.fired_handle == '0 && !busy, "tick done result malformed")
  `HMTQ_ASSERT_IMP(a_fired_mid, strobe && result.kind == KIND_FIRED, !result.last && busy, "fired result ended the tick")
  `HMTQ_ASSERT_IMP(a_pending_cap, strobe, result.pending <= PEND_BITS'(CAPACITY), "pending count above capacity")

endmodule

bind min_heap_timer_queue hmtq_checker #(.CAPACITY(CAPACITY)) u_hmtq_checker (.*);

/* bench/min_heap_timer_queue_test.sv */
// self-checking bench for the min-heap timer queue: directed and random add, cancel and tick
// items, results checked against an in-bench heap predictor; needs hmtq_pkg and the rtl
`timescale 1ns / 100ps

module min_heap_timer_queue_test;
  import hmtq_pkg::*;

  localparam int CAPACITY = 32;
  localparam int ITEM_TARGET = 380;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 64;
  localparam int REPORT_LIMIT = 10;
  localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
  localparam logic [TIME_BITS-1:0] TIME_TOP = '1;
  localparam logic [DELAY_BITS-1:0] DELAY_TOP = '1;

  typedef struct {
    in_t cmd;
    int  gap;
    bit  settle;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  cmd = '0;
  logic busy;
  logic strobe;
  out_t result;

  min_heap_timer_queue #(.CAPACITY(CAPACITY)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the heap
  logic [TIME_BITS-1:0]   model_expiry [CAPACITY];
  logic [HANDLE_BITS-1:0] model_handle [CAPACITY];
  int model_count = 0;
  bit model_cancelled [2**HANDLE_BITS];

  stim_t cmd_backlog[$];
  out_t  awaited_results[$];
  int    mismatches = 0;
  int    quiet_cycles = 0;
  int    gap_left = 0;
  bit    took_item = 1'b0;

  function automatic out_t make_result(logic [KIND_BITS-1:0] kind,
                                       logic [HANDLE_BITS-1:0] h, int pend, logic last);
    out_t r;
    r.kind = kind;
    r.fired_handle = h;
    r.pending = PEND_BITS'(pend);
    r.last = last;
    return r;
  endfunction

  task automatic predict_timer_results(input in_t item);
    logic [TIME_BITS:0]     total;
    logic [TIME_BITS-1:0]   due;
    logic [TIME_BITS-1:0]   moving_exp;
    logic [HANDLE_BITS-1:0] moving_h;
    logic [HANDLE_BITS-1:0] popped;
    int pos;
    int child;
    bit sifting;
    case (item.action)
      ACT_ADD: begin
        if (model_count >= CAPACITY) begin
          awaited_results.push_back(make_result(KIND_ADD_FULL, item.handle, model_count, 1'b1));
        end else begin
          total = {1'b0, item.now} + item.delay;
          due = total[TIME_BITS] ? TIME_TOP : total[TIME_BITS-1:0];
          model_cancelled[item.handle] = 1'b0;
          pos = model_count;
          model_count++;
          // stop below a parent that is earlier or equal
          while (pos > 0 && model_expiry[(pos - 1) / 2] > due) begin
            model_expiry[pos] = model_expiry[(pos - 1) / 2];
            model_handle[pos] = model_handle[(pos - 1) / 2];
            pos = (pos - 1) / 2;
          end
          model_expiry[pos] = due;
          model_handle[pos] = item.handle;
          awaited_results.push_back(make_result(KIND_ADD_OK, item.handle, model_count, 1'b1));
        end
      end
      ACT_CANCEL: begin
        model_cancelled[item.handle] = 1'b1;
        awaited_results.push_back(make_result(KIND_CANCEL_OK, item.handle, model_count, 1'b1));
      end
      ACT_TICK: begin
        while (model_count > 0 && model_expiry[0] <= item.now) begin
          popped = model_handle[0];
          model_count--;
          if (model_count > 0) begin
            moving_exp = model_expiry[model_count];
            moving_h = model_handle[model_count];
            pos = 0;
            sifting = 1'b1;
            while (sifting && pos * 2 + 1 < model_count) begin
              child = pos * 2 + 1;
              if (child + 1 < model_count && model_expiry[child + 1] < model_expiry[child])
                child++;
              if (model_expiry[child] < moving_exp) begin
                model_expiry[pos] = model_expiry[child];
                model_handle[pos] = model_handle[child];
                pos = child;
              end else begin
                sifting = 1'b0;
              end
            end
            model_expiry[pos] = moving_exp;
            model_handle[pos] = moving_h;
          end
          // cancelled entries leave the heap without a result
          if (!model_cancelled[popped])
            awaited_results.push_back(make_result(KIND_FIRED, popped, model_count, 1'b0));
        end
        awaited_results.push_back(make_result(KIND_DONE, '0, model_count, 1'b1));
      end
      default: ;
    endcase
  endtask

  always @(negedge clk) begin : driver
    stim_t next_item;
    if (rst) begin
      start <= 1'b0;
    end else if (start) begin
      if (took_item) begin
        if (cmd_backlog.size() != 0 && cmd_backlog[0].gap == 0 && !cmd_backlog[0].settle) begin
          next_item = cmd_backlog.pop_front();
          cmd <= next_item.cmd;
        end else begin
          start <= 1'b0;
          // this falling edge already starts the idle stretch
          if (cmd_backlog.size() != 0)
            gap_left = cmd_backlog[0].gap - 1;
        end
      end
    end else if (cmd_backlog.size() != 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (!cmd_backlog[0].settle || awaited_results.size() == 0) begin
        next_item = cmd_backlog.pop_front();
        cmd <= next_item.cmd;
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_t want;
    bit   accepted;
    if (rst) begin
      took_item <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      accepted = start && !busy;
      took_item <= accepted;
      // results of the previous item come first
      if (strobe) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: kind %0d handle %0d pending %0d last %0d",
                     result.kind, result.fired_handle, result.pending, result.last);
        end else begin
          want = awaited_results.pop_front();
          if (result.kind !== want.kind || result.fired_handle !== want.fired_handle ||
              result.pending !== want.pending || result.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result differs: want kind %0d handle %0d pending %0d last %0d, %s",
                       want.kind, want.fired_handle, want.pending, want.last,
                       $sformatf("got kind %0d handle %0d pending %0d last %0d",
                                 result.kind, result.fired_handle, result.pending,
                                 result.last));
          end
        end
      end
      if (accepted)
        predict_timer_results(cmd);
      quiet_cycles <= (strobe || accepted) ? 0 : quiet_cycles + 1;
    end
  end

  task automatic queue_item(input logic [ACTION_BITS-1:0] act, input logic [HANDLE_BITS-1:0] h,
                            input logic [DELAY_BITS-1:0] d, input logic [TIME_BITS-1:0] t,
                            input int gap, input bit settle);
    stim_t s;
    s.cmd.action = act;
    s.cmd.handle = h;
    s.cmd.delay = d;
    s.cmd.now = t;
    s.gap = gap;
    s.settle = settle;
    cmd_backlog.push_back(s);
  endtask

  initial begin : stimulus
    int phase;
    int phase_idx;
    int len;
    int roll;
    int made;
    bit calm;
    bit timed_out;
    logic [ACTION_BITS-1:0] act;
    logic [HANDLE_BITS-1:0] h;
    logic [DELAY_BITS-1:0]  d;
    logic [TIME_BITS-1:0]   t;
    logic [TIME_BITS-1:0]   gen_clock;
    logic [HANDLE_BITS-1:0] recent[$];

    // directed: empty tick, saturation, equal expiry, cancel marks, unused code
    queue_item(ACT_TICK, 8'd0, 20'd0, 32'd0, 0, 1'b0);
    queue_item(ACT_ADD, 8'd0, 20'd0, 32'd0, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_ADD, 8'd255, DELAY_TOP, TIME_TOP, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_ADD, 8'd1, DELAY_TOP, 32'hFFFF_F000, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_ADD, 8'd2, 20'd5, 32'd10, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_ADD, 8'd3, 20'd5, 32'd10, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_CANCEL, 8'd2, DELAY_TOP, TIME_TOP, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_CANCEL, 8'd77, 20'd0, 32'd0, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_UNUSED, 8'd255, DELAY_TOP, TIME_TOP, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_TICK, 8'd255, DELAY_TOP, 32'd14, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_TICK, 8'd0, 20'd0, 32'd15, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_ADD, 8'd77, 20'd1, 32'd20, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_ADD, 8'd2, 20'd0, 32'd20, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_TICK, 8'd0, 20'd0, 32'd21, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_CANCEL, 8'd1, 20'd0, 32'd0, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_TICK, 8'd0, 20'd0, TIME_TOP, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_TICK, 8'd0, 20'd0, TIME_TOP, $urandom_range(0, 4), 1'b0);
    // one mark covers both queued entries of a handle
    queue_item(ACT_ADD, 8'd9, 20'd3, 32'd0, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_ADD, 8'd9, 20'd4, 32'd0, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_CANCEL, 8'd9, 20'd0, 32'd0, $urandom_range(0, 4), 1'b0);
    queue_item(ACT_TICK, 8'd0, 20'd0, 32'd10, $urandom_range(0, 4), 1'b0);

    // random phases: fill to full, mixed, draining ticks, near the top of time
    made = cmd_backlog.size();
    phase_idx = 0;
    gen_clock = 32'd100;
    while (made < ITEM_TARGET) begin
      phase = (phase_idx < 4) ? phase_idx : $urandom_range(0, 3);
      calm = ($urandom_range(0, 3) == 0);
      len = (phase == 0) ? 48 : $urandom_range(20, 30);
      if (phase == 3)
        gen_clock = TIME_TOP - $urandom_range(0, 4000);
      for (int i = 0; i < len; i++) begin
        roll = $urandom_range(0, 99);
        if (phase != 3 && $urandom_range(0, 49) == 0)
          gen_clock = $urandom();
        case (phase)
          0: act = (roll < 90) ? ACT_ADD : ACT_CANCEL;
          1: act = (roll < 45) ? ACT_ADD : (roll < 60) ? ACT_CANCEL :
                   (roll < 97) ? ACT_TICK : ACT_UNUSED;
          2: act = (roll < 15) ? ACT_ADD : (roll < 25) ? ACT_CANCEL : ACT_TICK;
          default: act = (roll < 50) ? ACT_ADD : (roll < 65) ? ACT_CANCEL : ACT_TICK;
        endcase
        if (phase == 3 && i == len - 1)
          act = ACT_TICK;
        if (recent.size() != 0 && $urandom_range(0, 9) < 6)
          h = recent[$urandom_range(0, recent.size() - 1)];
        else
          h = $urandom_range(0, 255);
        d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DELAY_TOP) : $urandom_range(0, 63);
        t = gen_clock;
        if (act == ACT_ADD) begin
          recent.push_back(h);
          if (recent.size() > 12)
            recent.delete(0);
        end else if (act == ACT_CANCEL) begin
          t = $urandom();
          d = $urandom_range(0, DELAY_TOP);
        end else if (act == ACT_TICK) begin
          h = $urandom_range(0, 255);
          d = $urandom_range(0, DELAY_TOP);
          if (phase == 3) begin
            t = (i == len - 1) ? TIME_TOP : gen_clock;
          end else begin
            gen_clock = gen_clock + $urandom_range(0, (phase == 2) ? 200 : 20);
            if (phase == 2 && $urandom_range(0, 4) == 0)
              gen_clock = gen_clock + $urandom_range(0, 1 << 21);
            t = gen_clock;
          end
        end
        queue_item(act, h, d, t, calm ? 0 : $urandom_range(0, 4),
                   i == 0 && (phase_idx == 0 || $urandom_range(0, 2) == 0));
        if (act != ACT_UNUSED)
          made++;
      end
      if (phase == 3)
        gen_clock = $urandom_range(0, 1000);
      phase_idx++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while ((cmd_backlog.size() != 0 || start) && quiet_cycles < QUIET_LIMIT)
      @(negedge clk);
    while (awaited_results.size() != 0 && quiet_cycles < QUIET_LIMIT)
      @(negedge clk);
    timed_out = (quiet_cycles >= QUIET_LIMIT);
    if (!timed_out)
      repeat (TAIL_CYCLES) @(negedge clk);

    if (!timed_out && mismatches == 0 && awaited_results.size() == 0) begin
      $display("min_heap_timer_queue: match");
    end else begin
      $display("min_heap_timer_queue: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/hmtq_pkg.sv
hdl/hmtq_heap_ram.sv
hdl/hmtq_cancel.sv
hdl/min_heap_timer_queue.sv
hdl/hmtq_checker.sv
bench/min_heap_timer_queue_test.sv
